// ===== design/aavr_pkg.sv =====
package aavr_pkg;

    localparam int ANGLE_W    = 16;
    localparam int ATAN_LEN   = 24;
    localparam int SHIFT_W    = 6;
    localparam int NORM_W     = 31;
    localparam int SQ_W       = 64;
    localparam int LEN_W      = 32;
    localparam int REM_W      = 34;
    localparam int SQRT_STEPS = 32;
    localparam int DIV_STEPS  = 31;
    localparam int UNIT_W     = 32;
    localparam int CS_W       = 34;
    localparam int Z_W        = 35;
    localparam int NORM_LAT   = 6;
    localparam int MAT_LAT    = 7;

    localparam logic signed [31:0]    ONE_Q30     = 32'sd1073741824;
    localparam logic signed [Z_W-1:0] PI_Q30      = 35'sd3373259426;
    localparam logic signed [Z_W-1:0] HALF_PI_Q30 = 35'sd1686629713;
    localparam logic signed [CS_W-1:0] GAIN_Q30   = 34'sd652032874;

    typedef logic [29:0] t_atan;

    localparam t_atan ATAN_Q30 [ATAN_LEN] = '{
        30'd843314856, 30'd497837829, 30'd263043836, 30'd133525158,
        30'd67021686,  30'd33543515,  30'd16775850,  30'd8388437,
        30'd4194282,   30'd2097149,   30'd1048575,   30'd524287,
        30'd262143,    30'd131071,    30'd65535,     30'd32767,
        30'd16383,     30'd8191,      30'd4095,      30'd2047,
        30'd1023,      30'd511,       30'd255,       30'd127
    };

endpackage

// ===== design/aavr_delay.sv =====
module aavr_delay #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [WIDTH-1:0] i_d,
    output logic [WIDTH-1:0] o_d
);

    logic [WIDTH-1:0] r_tap [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tap[0] <= i_d;
            for (int k = 1; k < DEPTH; k++) begin
                r_tap[k] <= r_tap[k-1];
            end
        end
    end

    assign o_d = r_tap[DEPTH-1];

endmodule

// ===== design/aavr_norm.sv =====
module aavr_norm #(
    parameter int VEC_WIDTH = 32
) (
    input  logic                                  i_clk,
    input  logic                                  i_en,
    input  logic [2:0][VEC_WIDTH-1:0]             i_axis,
    output logic [aavr_pkg::SQ_W-1:0]             o_sq,
    output logic [2:0][aavr_pkg::NORM_W-1:0]      o_mag,
    output logic [2:0]                            o_neg,
    output logic                                  o_zero
);

    localparam int W   = VEC_WIDTH;
    localparam int NW  = aavr_pkg::NORM_W;
    localparam int SW  = aavr_pkg::SHIFT_W;
    localparam int EW  = W + NW;

    logic [2:0][W-1:0]    r_mag1, r_mag2, r_mag3;
    logic [2:0]           r_neg1, r_neg2, r_neg3, r_neg4, r_neg5, r_neg6;
    logic [W-1:0]         r_max2;
    logic                 r_zero3, r_zero4, r_zero5, r_zero6;
    logic [SW-1:0]        r_pos3;
    logic [2:0][NW-1:0]   r_mag4, r_mag5, r_mag6;
    logic [2:0][2*NW-1:0] r_sqr5;
    logic [aavr_pkg::SQ_W-1:0] r_sq6;

    logic [2:0][W-1:0]    n_mag1;
    logic [W-1:0]         n_max2;
    logic [SW-1:0]        n_pos3;
    logic [EW-1:0]        n_ext [3];
    logic [EW-1:0]        n_sh  [3];
    logic [2:0][NW-1:0]   n_mag4;
    logic [2:0][2*NW-1:0] n_sqr5;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_mag1[i] = i_axis[i][W-1] ? W'(-i_axis[i]) : i_axis[i];
        end
        n_max2 = r_mag1[0];
        if (r_mag1[1] > n_max2) n_max2 = r_mag1[1];
        if (r_mag1[2] > n_max2) n_max2 = r_mag1[2];
        n_pos3 = '0;
        for (int k = 0; k < W; k++) begin
            if (r_max2[k]) n_pos3 = SW'(k);
        end
        // Bring the largest magnitude to bit 30, keeping the direction.
        for (int i = 0; i < 3; i++) begin
            n_ext[i] = EW'(r_mag3[i]);
            if (r_pos3 >= SW'(NW - 1)) begin
                n_sh[i] = n_ext[i] >> (r_pos3 - SW'(NW - 1));
            end else begin
                n_sh[i] = n_ext[i] << (SW'(NW - 1) - r_pos3);
            end
            n_mag4[i] = n_sh[i][NW-1:0];
            n_sqr5[i] = r_mag4[i] * r_mag4[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mag1  <= n_mag1;
            for (int i = 0; i < 3; i++) begin
                r_neg1[i] <= i_axis[i][W-1];
            end
            r_max2  <= n_max2;
            r_mag2  <= r_mag1;
            r_neg2  <= r_neg1;
            r_zero3 <= (r_max2 == '0);
            r_pos3  <= n_pos3;
            r_mag3  <= r_mag2;
            r_neg3  <= r_neg2;
            r_mag4  <= n_mag4;
            r_zero4 <= r_zero3;
            r_neg4  <= r_neg3;
            r_sqr5  <= n_sqr5;
            r_mag5  <= r_mag4;
            r_zero5 <= r_zero4;
            r_neg5  <= r_neg4;
            r_sq6   <= aavr_pkg::SQ_W'(r_sqr5[0]) + aavr_pkg::SQ_W'(r_sqr5[1])
                     + aavr_pkg::SQ_W'(r_sqr5[2]);
            r_mag6  <= r_mag5;
            r_zero6 <= r_zero5;
            r_neg6  <= r_neg5;
        end
    end

    assign o_sq   = r_sq6;
    assign o_mag  = r_mag6;
    assign o_neg  = r_neg6;
    assign o_zero = r_zero6;

endmodule

// ===== design/aavr_sqrt.sv =====
module aavr_sqrt (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [aavr_pkg::SQ_W-1:0]   i_sq,
    output logic [aavr_pkg::LEN_W-1:0]  o_len
);

    localparam int N  = aavr_pkg::SQRT_STEPS;
    localparam int RW = aavr_pkg::REM_W;
    localparam int LW = aavr_pkg::LEN_W;
    localparam int VW = aavr_pkg::SQ_W;

    logic [RW-1:0] r_rem  [N-1];
    logic [VW-1:0] r_val  [N-1];
    logic [LW-1:0] r_root [N];

    // One result bit per stage: two radicand bits enter the remainder each step.
    for (genvar k = 0; k < N; k++) begin : g_step
        logic [RW-1:0] rem_in;
        logic [VW-1:0] val_in;
        logic [LW-1:0] root_in;
        logic [RW+1:0] part;
        logic [RW+1:0] trial;
        logic          ge;

        if (k == 0) begin : g_first
            assign rem_in  = '0;
            assign val_in  = i_sq;
            assign root_in = '0;
        end else begin : g_next
            assign rem_in  = r_rem[k-1];
            assign val_in  = r_val[k-1];
            assign root_in = r_root[k-1];
        end

        assign part  = {rem_in, val_in[VW-1:VW-2]};
        assign trial = (RW + 2)'({root_in, 2'b01});
        assign ge    = (part >= trial);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_root[k] <= {root_in[LW-2:0], ge};
            end
        end

        if (k < N - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k] <= ge ? RW'(part - trial) : part[RW-1:0];
                    r_val[k] <= {val_in[VW-3:0], 2'b00};
                end
            end
        end
    end

    assign o_len = r_root[N-1];

endmodule

// ===== design/aavr_div.sv =====
module aavr_div (
    input  logic                              i_clk,
    input  logic                              i_en,
    input  logic [2:0][aavr_pkg::NORM_W-1:0]  i_mag,
    input  logic [aavr_pkg::LEN_W-1:0]        i_len,
    output logic [2:0][aavr_pkg::NORM_W-1:0]  o_quot
);

    localparam int N  = aavr_pkg::DIV_STEPS;
    localparam int NW = aavr_pkg::NORM_W;
    localparam int LW = aavr_pkg::LEN_W;

    logic [2:0][NW-1:0] r_quot [N];
    logic [2:0][LW-1:0] r_rem  [N-1];
    logic [LW-1:0]      r_len  [N-1];

    // Restoring division of mag * 2^30 by the length, three lanes sharing
    // the divisor; the dividend has only the magnitude's low bit below bit 31.
    for (genvar k = 0; k < N; k++) begin : g_step
        logic [2:0][LW-1:0] rem_in;
        logic [2:0][NW-1:0] quot_in;
        logic [2:0]         bit_in;
        logic [LW-1:0]      len_in;
        logic [LW:0]        part [3];
        logic [2:0]         ge;

        if (k == 0) begin : g_first
            always_comb begin
                for (int l = 0; l < 3; l++) begin
                    rem_in[l] = LW'(i_mag[l][NW-1:1]);
                    bit_in[l] = i_mag[l][0];
                end
            end
            assign quot_in = '0;
            assign len_in  = i_len;
        end else begin : g_next
            assign rem_in  = r_rem[k-1];
            assign bit_in  = '0;
            assign quot_in = r_quot[k-1];
            assign len_in  = r_len[k-1];
        end

        always_comb begin
            for (int l = 0; l < 3; l++) begin
                part[l] = {rem_in[l], bit_in[l]};
                ge[l]   = (part[l] >= {1'b0, len_in});
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                for (int l = 0; l < 3; l++) begin
                    r_quot[k][l] <= {quot_in[l][NW-2:0], ge[l]};
                end
            end
        end

        if (k < N - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_len[k] <= len_in;
                    for (int l = 0; l < 3; l++) begin
                        r_rem[k][l] <= ge[l] ? LW'(part[l] - {1'b0, len_in})
                                             : part[l][LW-1:0];
                    end
                end
            end
        end
    end

    assign o_quot = r_quot[N-1];

endmodule

// ===== design/aavr_cordic.sv =====
module aavr_cordic #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_en,
    input  logic signed [aavr_pkg::ANGLE_W-1:0]  i_angle,
    output logic signed [aavr_pkg::CS_W-1:0]     o_cos,
    output logic signed [aavr_pkg::CS_W-1:0]     o_sin
);

    localparam int NCOR = (CORDIC_STAGES < aavr_pkg::ATAN_LEN) ?
                          CORDIC_STAGES : aavr_pkg::ATAN_LEN;
    localparam int CW   = aavr_pkg::CS_W;
    localparam int ZW   = aavr_pkg::Z_W;
    localparam int AW   = aavr_pkg::ANGLE_W;

    logic signed [CW-1:0] r_x [NCOR+1];
    logic signed [CW-1:0] r_y [NCOR+1];
    logic signed [ZW-1:0] r_z [NCOR];
    logic                 r_flip [NCOR+1];
    logic signed [CW-1:0] r_cos, r_sin;

    logic signed [ZW-1:0] n_z0, n_zf;
    logic                 n_flip;

    // Angles beyond a quarter turn are folded by pi; sine and cosine are
    // then negated at the end.
    always_comb begin
        n_z0 = signed'({{(ZW - AW - 17){i_angle[AW-1]}}, i_angle, 17'b0});
        priority if (n_z0 > aavr_pkg::HALF_PI_Q30) begin
            n_zf   = n_z0 - aavr_pkg::PI_Q30;
            n_flip = 1'b1;
        end else if (n_z0 < -aavr_pkg::HALF_PI_Q30) begin
            n_zf   = n_z0 + aavr_pkg::PI_Q30;
            n_flip = 1'b1;
        end else begin
            n_zf   = n_z0;
            n_flip = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0]    <= aavr_pkg::GAIN_Q30;
            r_y[0]    <= '0;
            r_z[0]    <= n_zf;
            r_flip[0] <= n_flip;
            r_cos     <= r_flip[NCOR] ? -r_x[NCOR] : r_x[NCOR];
            r_sin     <= r_flip[NCOR] ? -r_y[NCOR] : r_y[NCOR];
        end
    end

    for (genvar k = 1; k <= NCOR; k++) begin : g_stage
        logic signed [CW-1:0] dx, dy;
        logic signed [ZW-1:0] ang;
        logic                 up;

        assign dx  = r_y[k-1] >>> (k - 1);
        assign dy  = r_x[k-1] >>> (k - 1);
        assign ang = signed'(ZW'(aavr_pkg::ATAN_Q30[k-1]));
        assign up  = !r_z[k-1][ZW-1];

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[k]    <= up ? r_x[k-1] - dx : r_x[k-1] + dx;
                r_y[k]    <= up ? r_y[k-1] + dy : r_y[k-1] - dy;
                r_flip[k] <= r_flip[k-1];
            end
        end

        if (k < NCOR) begin : g_angle
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_z[k] <= up ? r_z[k-1] - ang : r_z[k-1] + ang;
                end
            end
        end
    end

    assign o_cos = r_cos;
    assign o_sin = r_sin;

endmodule

// ===== design/aavr_matrix.sv =====
module aavr_matrix #(
    parameter int VEC_WIDTH = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_en,
    input  logic [2:0][aavr_pkg::NORM_W-1:0]     i_quot,
    input  logic [2:0]                           i_neg,
    input  logic                                 i_zero,
    input  logic signed [aavr_pkg::CS_W-1:0]     i_cos,
    input  logic signed [aavr_pkg::CS_W-1:0]     i_sin,
    input  logic [2:0][VEC_WIDTH-1:0]            i_vec,
    output logic [2:0][VEC_WIDTH-1:0]            o_out,
    output logic                                 o_zero
);

    localparam int W   = VEC_WIDTH;
    localparam int UW  = aavr_pkg::UNIT_W;
    localparam int CW  = aavr_pkg::CS_W;
    localparam int TW  = CW + 1;
    localparam int PW  = 34;
    localparam int RW  = 36;
    localparam int HW  = W - 15;
    localparam int PHW = 32 + HW;
    localparam int PLW = 32 + 17;
    localparam int SW  = W + 18;
    localparam int AW  = SW + 2;

    localparam logic signed [RW-1:0] R_HI = RW'(aavr_pkg::ONE_Q30);
    localparam logic signed [RW-1:0] R_LO = -R_HI;
    localparam logic signed [AW-1:0] SAT_HI = {{(AW - W + 1){1'b0}}, {(W - 1){1'b1}}};
    localparam logic signed [AW-1:0] SAT_LO = {{(AW - W + 1){1'b1}}, {(W - 1){1'b0}}};

    logic signed [UW-1:0]  r_n1 [3], r_n2 [3];
    logic signed [TW-1:0]  r_t1;
    logic signed [CW-1:0]  r_c1, r_c2, r_c3, r_s1;
    logic signed [PW-1:0]  r_p2 [3], r_sn2 [3], r_sn3 [3];
    logic signed [PW-1:0]  r_tt3 [6];
    logic signed [31:0]    r_r4 [3][3];
    logic signed [PHW-1:0] r_ph5 [3][3];
    logic signed [PLW-1:0] r_pl5 [3][3];
    logic signed [SW-1:0]  r_tm6 [3][3];
    logic [2:0][W-1:0]     r_vec1, r_vec2, r_vec3, r_vec4, r_vec5, r_vec6, r_out7;
    logic                  r_zero1, r_zero2, r_zero3, r_zero4, r_zero5, r_zero6;
    logic                  r_zero7;

    logic signed [UW-1:0]      n_n1 [3];
    logic signed [TW+UW-1:0]   n_tp [3];
    logic signed [CW+UW-1:0]   n_sp [3];
    logic signed [PW+UW-1:0]   n_pp [6];
    logic signed [RW-1:0]      n_rs [3][3];
    logic signed [31:0]        n_r4 [3][3];
    logic signed [HW-1:0]      n_hi [3];
    logic signed [16:0]        n_lo [3];
    logic signed [PHW-1:0]     n_ph [3][3];
    logic signed [PLW-1:0]     n_pl [3][3];
    logic signed [SW-1:0]      n_sum [3][3];
    logic signed [AW-1:0]      n_acc [3];
    logic [2:0][W-1:0]         n_out7;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_n1[i] = i_neg[i] ? -signed'(UW'(i_quot[i])) : signed'(UW'(i_quot[i]));
            n_tp[i] = r_t1 * r_n1[i];
            n_sp[i] = r_s1 * r_n1[i];
        end

        // Products of (1 - cos) n_a with n_b: xx, yy, zz, xy, xz, yz.
        n_pp[0] = r_p2[0] * r_n2[0];
        n_pp[1] = r_p2[1] * r_n2[1];
        n_pp[2] = r_p2[2] * r_n2[2];
        n_pp[3] = r_p2[0] * r_n2[1];
        n_pp[4] = r_p2[0] * r_n2[2];
        n_pp[5] = r_p2[1] * r_n2[2];

        n_rs[0][0] = RW'(r_c3) + RW'(r_tt3[0]);
        n_rs[0][1] = RW'(r_tt3[3]) - RW'(r_sn3[2]);
        n_rs[0][2] = RW'(r_tt3[4]) + RW'(r_sn3[1]);
        n_rs[1][0] = RW'(r_tt3[3]) + RW'(r_sn3[2]);
        n_rs[1][1] = RW'(r_c3) + RW'(r_tt3[1]);
        n_rs[1][2] = RW'(r_tt3[5]) - RW'(r_sn3[0]);
        n_rs[2][0] = RW'(r_tt3[4]) - RW'(r_sn3[1]);
        n_rs[2][1] = RW'(r_tt3[5]) + RW'(r_sn3[0]);
        n_rs[2][2] = RW'(r_c3) + RW'(r_tt3[2]);

        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                priority if (n_rs[i][j] > R_HI) begin
                    n_r4[i][j] = 32'(R_HI);
                end else if (n_rs[i][j] < R_LO) begin
                    n_r4[i][j] = 32'(R_LO);
                end else begin
                    n_r4[i][j] = 32'(n_rs[i][j]);
                end
            end
        end

        // Each entry times a vector component, split at bit 16 so the
        // floor of the full product comes out exactly.
        for (int j = 0; j < 3; j++) begin
            n_hi[j] = HW'(signed'(r_vec4[j]) >>> 16);
            n_lo[j] = signed'({1'b0, r_vec4[j][15:0]});
        end
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                n_ph[i][j]  = r_r4[i][j] * n_hi[j];
                n_pl[i][j]  = r_r4[i][j] * n_lo[j];
                n_sum[i][j] = SW'(r_ph5[i][j]) + SW'(r_pl5[i][j] >>> 16);
            end
        end

        for (int i = 0; i < 3; i++) begin
            n_acc[i] = AW'(r_tm6[i][0]) + AW'(r_tm6[i][1]) + AW'(r_tm6[i][2]);
            priority if (r_zero6) begin
                n_out7[i] = r_vec6[i];
            end else if (n_acc[i] > SAT_HI) begin
                n_out7[i] = SAT_HI[W-1:0];
            end else if (n_acc[i] < SAT_LO) begin
                n_out7[i] = SAT_LO[W-1:0];
            end else begin
                n_out7[i] = n_acc[i][W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_n1    <= n_n1;
            r_t1    <= TW'(aavr_pkg::ONE_Q30) - TW'(i_cos);
            r_c1    <= i_cos;
            r_s1    <= i_sin;
            r_vec1  <= i_vec;
            r_zero1 <= i_zero;

            for (int i = 0; i < 3; i++) begin
                r_p2[i]  <= PW'(n_tp[i] >>> 30);
                r_sn2[i] <= PW'(n_sp[i] >>> 30);
            end
            r_n2    <= r_n1;
            r_c2    <= r_c1;
            r_vec2  <= r_vec1;
            r_zero2 <= r_zero1;

            for (int k = 0; k < 6; k++) begin
                r_tt3[k] <= PW'(n_pp[k] >>> 30);
            end
            r_sn3   <= r_sn2;
            r_c3    <= r_c2;
            r_vec3  <= r_vec2;
            r_zero3 <= r_zero2;

            r_r4    <= n_r4;
            r_vec4  <= r_vec3;
            r_zero4 <= r_zero3;

            r_ph5   <= n_ph;
            r_pl5   <= n_pl;
            r_vec5  <= r_vec4;
            r_zero5 <= r_zero4;

            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_tm6[i][j] <= n_sum[i][j] >>> 14;
                end
            end
            r_vec6  <= r_vec5;
            r_zero6 <= r_zero5;

            r_out7  <= n_out7;
            r_zero7 <= r_zero6;
        end
    end

    assign o_out  = r_out7;
    assign o_zero = r_zero7;

endmodule

// ===== design/axis_angle_vector_rotate_unit.sv =====
// Rotates a Q16.16 vector about an axis of any length by a Q3.13 angle in
// radians (right-handed). The unit accepts one transaction per cycle and
// returns each result after these steps in order: find the axis magnitudes,
// scale them and sum their squares; take the one-bit-per-stage square root;
// run the one-bit-per-stage division that yields the unit axis; build the
// rotation matrix and apply it. The CORDIC for sine and cosine runs beside
// the root and the division, so CORDIC_STAGES does not change the latency.
// A stall on the output halts the whole pipeline while a result waits. A
// zero axis returns the vector unchanged with o_zero_axis set. Results
// saturate to the signed VEC_WIDTH range.
module axis_angle_vector_rotate_unit #(
    parameter int VEC_WIDTH     = 32,
    parameter int CORDIC_STAGES = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic signed [VEC_WIDTH-1:0]           i_vec_x,
    input  logic signed [VEC_WIDTH-1:0]           i_vec_y,
    input  logic signed [VEC_WIDTH-1:0]           i_vec_z,
    input  logic signed [VEC_WIDTH-1:0]           i_axis_x,
    input  logic signed [VEC_WIDTH-1:0]           i_axis_y,
    input  logic signed [VEC_WIDTH-1:0]           i_axis_z,
    input  logic signed [aavr_pkg::ANGLE_W-1:0]   i_angle,
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic signed [VEC_WIDTH-1:0]           o_out_x,
    output logic signed [VEC_WIDTH-1:0]           o_out_y,
    output logic signed [VEC_WIDTH-1:0]           o_out_z,
    output logic                                  o_zero_axis
);

    localparam int W       = VEC_WIDTH;
    localparam int NW      = aavr_pkg::NORM_W;
    localparam int NCOR    = (CORDIC_STAGES < aavr_pkg::ATAN_LEN) ?
                             CORDIC_STAGES : aavr_pkg::ATAN_LEN;
    localparam int COR_LAT = NCOR + 2;
    localparam int DIV_END = aavr_pkg::NORM_LAT + aavr_pkg::SQRT_STEPS
                           + aavr_pkg::DIV_STEPS;
    localparam int LAT     = DIV_END + aavr_pkg::MAT_LAT;
    localparam int ANG_DLY = DIV_END - COR_LAT;

    logic [LAT-1:0] r_valid;
    logic           en;

    logic [aavr_pkg::SQ_W-1:0]         sq;
    logic [2:0][NW-1:0]                mag, mag_d;
    logic [2:0]                        neg, neg_d;
    logic                              zero, zero_d;
    logic [aavr_pkg::LEN_W-1:0]        len;
    logic [2:0][NW-1:0]                quot;
    logic [aavr_pkg::ANGLE_W-1:0]      angle_d;
    logic signed [aavr_pkg::CS_W-1:0]  cos_v, sin_v;
    logic [2:0][W-1:0]                 vec_d, res;

    // The whole pipeline moves together; it holds in reset and while a result waits.
    assign en      = i_rst_n && !(o_valid && i_stall);
    assign o_stall = !en;
    assign o_valid = r_valid[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (en) begin
            r_valid <= {r_valid[LAT-2:0], i_valid};
        end
    end

    aavr_norm #(.VEC_WIDTH(W)) u_norm (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_axis ({i_axis_z, i_axis_y, i_axis_x}),
        .o_sq   (sq),
        .o_mag  (mag),
        .o_neg  (neg),
        .o_zero (zero)
    );

    aavr_sqrt u_sqrt (
        .i_clk (i_clk),
        .i_en  (en),
        .i_sq  (sq),
        .o_len (len)
    );

    aavr_delay #(.WIDTH(3 * NW), .DEPTH(aavr_pkg::SQRT_STEPS)) u_mag_dly (
        .i_clk (i_clk),
        .i_en  (en),
        .i_d   (mag),
        .o_d   (mag_d)
    );

    aavr_div u_div (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_mag  (mag_d),
        .i_len  (len),
        .o_quot (quot)
    );

    aavr_delay #(.WIDTH(4),
                 .DEPTH(aavr_pkg::SQRT_STEPS + aavr_pkg::DIV_STEPS)) u_flag_dly (
        .i_clk (i_clk),
        .i_en  (en),
        .i_d   ({zero, neg}),
        .o_d   ({zero_d, neg_d})
    );

    aavr_delay #(.WIDTH(aavr_pkg::ANGLE_W), .DEPTH(ANG_DLY)) u_ang_dly (
        .i_clk (i_clk),
        .i_en  (en),
        .i_d   (i_angle),
        .o_d   (angle_d)
    );

    aavr_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_cordic (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_angle (signed'(angle_d)),
        .o_cos   (cos_v),
        .o_sin   (sin_v)
    );

    aavr_delay #(.WIDTH(3 * W), .DEPTH(DIV_END)) u_vec_dly (
        .i_clk (i_clk),
        .i_en  (en),
        .i_d   ({i_vec_z, i_vec_y, i_vec_x}),
        .o_d   (vec_d)
    );

    aavr_matrix #(.VEC_WIDTH(W)) u_matrix (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_quot (quot),
        .i_neg  (neg_d),
        .i_zero (zero_d),
        .i_cos  (cos_v),
        .i_sin  (sin_v),
        .i_vec  (vec_d),
        .o_out  (res),
        .o_zero (o_zero_axis)
    );

    assign o_out_x = signed'(res[0]);
    assign o_out_y = signed'(res[1]);
    assign o_out_z = signed'(res[2]);

endmodule

// ===== design/aavr_checker.sv =====
module aavr_checker #(
    parameter int VEC_WIDTH = 32
) (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 i_valid,
    input logic                                 o_stall,
    input logic signed [VEC_WIDTH-1:0]          i_vec_x,
    input logic signed [VEC_WIDTH-1:0]          i_vec_y,
    input logic signed [VEC_WIDTH-1:0]          i_vec_z,
    input logic signed [VEC_WIDTH-1:0]          i_axis_x,
    input logic signed [VEC_WIDTH-1:0]          i_axis_y,
    input logic signed [VEC_WIDTH-1:0]          i_axis_z,
    input logic signed [aavr_pkg::ANGLE_W-1:0]  i_angle,
    input logic                                 o_valid,
    input logic                                 i_stall,
    input logic signed [VEC_WIDTH-1:0]          o_out_x,
    input logic signed [VEC_WIDTH-1:0]          o_out_y,
    input logic signed [VEC_WIDTH-1:0]          o_out_z,
    input logic                                 o_zero_axis
);

    // The input side is held off only in reset or while a result waits.
    a_stall_source: assert property (@(posedge i_clk)
        o_stall == (!i_rst_n || (o_valid && i_stall)))
        else $error("input stall does not follow output backpressure");

    // A waiting result stays put until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_out_x) && $stable(o_out_y)
                              && $stable(o_out_z) && $stable(o_zero_axis))
        else $error("stalled result changed");

    // An offered transaction that is held off stays on the input unchanged.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_stall |=> i_valid && $stable(i_vec_x) && $stable(i_vec_y)
                              && $stable(i_vec_z) && $stable(i_axis_x)
                              && $stable(i_axis_y) && $stable(i_axis_z)
                              && $stable(i_angle))
        else $error("stalled input transaction changed");

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

endmodule

bind axis_angle_vector_rotate_unit aavr_checker #(.VEC_WIDTH(VEC_WIDTH)) u_checker (.*);
